@@ sv/rti_pkg.sv @@
// Shared types, constants and micro-step helpers for the ray-triangle intersection unit.
`default_nettype none

package rti_pkg;

    // Field and datapath widths.
    localparam int COORD_W   = 24;
    localparam int EPS_W     = 16;
    localparam int VEC_W     = 25;
    localparam int WIDE_W    = 52;
    localparam int ACC_W     = 80;
    localparam int PART_W    = 26;
    localparam int PROD_W    = 53;
    localparam int QUOT_W    = 42;
    localparam int DIV_W     = 128;
    localparam int DCNT_W    = 6;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd4;

    // Opcodes and the unused vertex select code.
    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_TEST   = 1'b1;
    localparam logic [1:0] VSEL_NONE = 2'd3;

    // Micro-step counter range for one cross or dot product.
    localparam logic [2:0] MAC_LAST = 3'd5;

    // Saturation bounds of the distance result.
    localparam logic signed [QUOT_W-1:0] DIST_MAX = 42'sd8388607;
    localparam logic signed [QUOT_W-1:0] DIST_MIN = -42'sd8388608;

    // Operand, part and destination selects for the multiply-accumulate unit.
    typedef enum logic [1:0] {AV_E1, AV_E2, AV_TV, AV_DIR} t_avec;
    typedef enum logic [2:0] {BV_N, BV_PV, BV_QV, BV_E1, BV_E2, BV_DIR} t_bvec;
    typedef enum logic [1:0] {PT_FULL, PT_LO, PT_HI} t_part;
    typedef enum logic [1:0] {DV_NONE, DV_N, DV_PV, DV_QV} t_dvec;

    typedef struct packed {
        t_avec      a_vec;
        logic [1:0] a_idx;
        t_bvec      b_vec;
        logic [1:0] b_idx;
        t_part      part;
        logic       clr;
        logic       neg;
        t_dvec      dst;
        logic [1:0] dst_idx;
    } t_step;

    // Controller states and division phases.
    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_DET, S_DCHK, S_PV, S_UNUM, S_DSTART, S_DWAIT,
        S_UCHK, S_QV, S_VNUM, S_VCHK, S_TNUM, S_EMIT
    } t_state;

    typedef enum logic [1:0] {PH_U, PH_V, PH_T} t_phase;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  ld_vertex;
        logic  ld_ray;
        logic  mac_en;
        t_step step;
        logic  det_ld;
        logic  div_start;
        logic  u_ld;
        logic  emit_miss;
        logic  emit_hit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic det_small;
        logic div_done;
        logic u_bad;
        logic v_bad;
    } t_dp_stat;

    // One step of a cross product r = a x b; two steps per component.
    function automatic t_step cross_step(t_avec a, t_bvec b, t_dvec d, logic [2:0] cnt);
        logic [1:0] k;
        logic [1:0] k1;
        logic [1:0] k2;
        t_step      s;
        k = cnt[2:1];
        case (k)
            2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
            2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
            default: begin k1 = 2'd0; k2 = 2'd1; end
        endcase
        s.a_vec   = a;
        s.b_vec   = b;
        s.part    = PT_FULL;
        s.clr     = ~cnt[0];
        s.neg     = cnt[0];
        s.dst     = cnt[0] ? d : DV_NONE;
        s.dst_idx = k;
        s.a_idx   = cnt[0] ? k2 : k1;
        s.b_idx   = cnt[0] ? k1 : k2;
        return s;
    endfunction

    // One step of a dot product with a wide second operand split in halves.
    function automatic t_step dot_step(t_avec a, t_bvec b, logic neg, logic [2:0] cnt);
        t_step s;
        s.a_vec   = a;
        s.b_vec   = b;
        s.a_idx   = cnt[2:1];
        s.b_idx   = cnt[2:1];
        s.part    = cnt[0] ? PT_HI : PT_LO;
        s.clr     = (cnt == 3'd0);
        s.neg     = neg;
        s.dst     = DV_NONE;
        s.dst_idx = 2'd0;
        return s;
    endfunction

endpackage

`default_nettype wire

@@ sv/rti_div.sv @@
// Restoring divider: truncated (num << F) / den with the magnitude clamped at 2^40.
`default_nettype none

module rti_div #(
    parameter int COORD_FRAC_BITS = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [rti_pkg::ACC_W-1:0]   i_num,
    input  wire logic signed [rti_pkg::ACC_W-1:0]   i_den,
    output logic                                    o_done,
    output logic signed [rti_pkg::QUOT_W-1:0]       o_quot
);
    import rti_pkg::*;

    localparam logic [QUOT_W-1:0] CLAMP = QUOT_W'(1) << (QUOT_W - 2);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_ds;
    logic [QUOT_W-1:0] r_q;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_neg;
    logic [ACC_W-1:0]  nabs;
    logic [ACC_W-1:0]  dabs;
    logic [QUOT_W-1:0] mag;

    // Operand magnitudes.
    assign nabs = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign dabs = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);

    // Control: iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(QUOT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // One quotient bit per cycle, the top bit flagging overflow.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_W'(nabs) << COORD_FRAC_BITS;
            r_ds  <= DIV_W'(dabs) << (QUOT_W - 1);
            r_q   <= '0;
            r_neg <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
        end else if (r_cnt != '0) begin
            if (r_rem >= r_ds) begin
                r_rem <= r_rem - r_ds;
                r_q   <= {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QUOT_W-2:0], 1'b0};
            end
            r_ds <= r_ds >> 1;
        end
    end

    // Clamp and apply the sign.
    assign mag    = (r_q[QUOT_W-1] || (r_q > CLAMP)) ? CLAMP : r_q;
    assign o_quot = r_neg ? -$signed(mag) : $signed(mag);
    assign o_done = (r_cnt == '0);

endmodule

`default_nettype wire

@@ sv/rti_datapath.sv @@
// Datapath: vertex and vector registers, shared multiply-accumulate, divider and result checks.
`default_nettype none

module rti_datapath #(
    parameter int COORD_FRAC_BITS = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire rti_pkg::t_dp_cmd                     i_cmd,
    output rti_pkg::t_dp_stat                         o_stat,
    input  wire logic [1:0]                           i_vertex_select,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_pos_x,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_pos_y,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_pos_z,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_dir_x,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_dir_y,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_dir_z,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rti_pkg::EPS_W-1:0]            i_cfg_wdata,
    output logic                                      o_valid,
    output logic                                      o_hit,
    output logic signed [rti_pkg::COORD_W-1:0]        o_distance,
    output logic                                      o_saturated
);
    import rti_pkg::*;

    localparam int CHK_W = QUOT_W + 2;

    logic signed [COORD_W-1:0] r_vtx [9];
    logic signed [WIDE_W-1:0]  r_norm [3];
    logic signed [WIDE_W-1:0]  r_pv [3];
    logic signed [WIDE_W-1:0]  r_qv [3];
    logic signed [VEC_W-1:0]   r_tv [3];
    logic signed [COORD_W-1:0] r_dir [3];
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_det;
    logic signed [QUOT_W-1:0]  r_u;
    logic [EPS_W-1:0]          r_eps;

    logic signed [COORD_W-1:0] pos [3];
    logic signed [COORD_W-1:0] dir [3];
    logic signed [VEC_W-1:0]   e1 [3];
    logic signed [VEC_W-1:0]   e2 [3];
    logic signed [VEC_W-1:0]   a_vec [3];
    logic signed [WIDE_W-1:0]  b_vec [3];
    logic signed [VEC_W-1:0]   a_sel;
    logic signed [WIDE_W-1:0]  b_full;
    logic signed [PART_W-1:0]  a_op;
    logic signed [PART_W:0]    b_op;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]          acc_abs;
    logic [ACC_W-1:0]          eps_sc;
    logic                      div_done;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [CHK_W-1:0]   q44;
    logic signed [CHK_W-1:0]   u44;
    logic signed [CHK_W-1:0]   e44;
    logic signed [CHK_W-1:0]   one44;
    logic                      sat_hi;
    logic                      sat_lo;

    assign pos = '{i_pos_x, i_pos_y, i_pos_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};

    // Triangle edges from the stored vertices.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = VEC_W'(r_vtx[3 + k]) - VEC_W'(r_vtx[k]);
            e2[k] = VEC_W'(r_vtx[6 + k]) - VEC_W'(r_vtx[k]);
        end
    end

    // First operand select.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (i_cmd.step.a_vec)
                AV_E1:   a_vec[k] = e1[k];
                AV_E2:   a_vec[k] = e2[k];
                AV_TV:   a_vec[k] = r_tv[k];
                default: a_vec[k] = VEC_W'(r_dir[k]);
            endcase
        end
        case (i_cmd.step.a_idx)
            2'd0:    a_sel = a_vec[0];
            2'd1:    a_sel = a_vec[1];
            default: a_sel = a_vec[2];
        endcase
        a_op = PART_W'(a_sel);
    end

    // Second operand select and half split.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (i_cmd.step.b_vec)
                BV_N:    b_vec[k] = r_norm[k];
                BV_PV:   b_vec[k] = r_pv[k];
                BV_QV:   b_vec[k] = r_qv[k];
                BV_E1:   b_vec[k] = WIDE_W'(e1[k]);
                BV_E2:   b_vec[k] = WIDE_W'(e2[k]);
                default: b_vec[k] = WIDE_W'(r_dir[k]);
            endcase
        end
        case (i_cmd.step.b_idx)
            2'd0:    b_full = b_vec[0];
            2'd1:    b_full = b_vec[1];
            default: b_full = b_vec[2];
        endcase
        case (i_cmd.step.part)
            PT_LO:   b_op = {1'b0, b_full[PART_W-1:0]};
            PT_HI:   b_op = {b_full[WIDE_W-1], b_full[WIDE_W-1:PART_W]};
            default: b_op = {b_full[PART_W-1], b_full[PART_W-1:0]};
        endcase
    end

    // Multiply and accumulate.
    assign prod     = a_op * b_op;
    assign term     = (i_cmd.step.part == PT_HI) ?
                      ({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} <<< PART_W) :
                      {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign acc_base = i_cmd.step.clr ? '0 : r_acc;
    assign acc_next = i_cmd.step.neg ? (acc_base - term) : (acc_base + term);

    // Triangle state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_vtx[k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_norm[k] <= '0;
            end
            r_eps <= EPS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    if (i_cmd.ld_vertex && (i_vertex_select == 2'(j))) begin
                        r_vtx[3 * j + k] <= pos[k];
                    end
                end
            end
            for (int k = 0; k < 3; k++) begin
                if (i_cmd.mac_en && (i_cmd.step.dst == DV_N) &&
                    (i_cmd.step.dst_idx == 2'(k))) begin
                    r_norm[k] <= acc_next[WIDE_W-1:0];
                end
            end
        end
    end

    // Per-test working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ray) begin
            for (int k = 0; k < 3; k++) begin
                r_tv[k]  <= VEC_W'(pos[k]) - VEC_W'(r_vtx[k]);
                r_dir[k] <= dir[k];
            end
        end
        if (i_cmd.mac_en) begin
            r_acc <= acc_next;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.mac_en && (i_cmd.step.dst_idx == 2'(k))) begin
                if (i_cmd.step.dst == DV_PV) begin
                    r_pv[k] <= acc_next[WIDE_W-1:0];
                end
                if (i_cmd.step.dst == DV_QV) begin
                    r_qv[k] <= acc_next[WIDE_W-1:0];
                end
            end
        end
        if (i_cmd.det_ld) begin
            r_det <= r_acc;
        end
        if (i_cmd.u_ld) begin
            r_u <= quot;
        end
    end

    // Shared divider.
    rti_div #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_acc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Determinant and barycentric checks.
    assign acc_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign eps_sc  = ACC_W'(r_eps) << (2 * COORD_FRAC_BITS);
    assign q44     = CHK_W'(quot);
    assign u44     = CHK_W'(r_u);
    assign e44     = CHK_W'({1'b0, r_eps});
    assign one44   = CHK_W'(1) << COORD_FRAC_BITS;

    always_comb begin
        o_stat.det_small = (acc_abs < eps_sc) || (acc_abs == '0);
        o_stat.div_done  = div_done;
        o_stat.u_bad     = (q44 < -e44) || (q44 > (one44 + e44));
        o_stat.v_bad     = (q44 < -e44) || ((u44 + q44) > (one44 + e44));
    end

    // Distance saturation.
    assign sat_hi = (quot > DIST_MAX);
    assign sat_lo = (quot < DIST_MIN);

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_miss | i_cmd.emit_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hit) begin
            o_hit       <= 1'b1;
            o_saturated <= sat_hi | sat_lo;
            if (sat_hi) begin
                o_distance <= DIST_MAX[COORD_W-1:0];
            end else if (sat_lo) begin
                o_distance <= DIST_MIN[COORD_W-1:0];
            end else begin
                o_distance <= quot[COORD_W-1:0];
            end
        end else if (i_cmd.emit_miss) begin
            o_hit       <= 1'b0;
            o_saturated <= 1'b0;
            o_distance  <= '0;
        end
    end

endmodule

`default_nettype wire

@@ sv/rti_ctrl.sv @@
// Controller: sequences loads and tests through the datapath steps.
`default_nettype none

module rti_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_opcode,
    input  wire logic [1:0]         i_vertex_select,
    output logic                    o_busy,
    output rti_pkg::t_dp_cmd        o_cmd,
    input  wire rti_pkg::t_dp_stat  i_stat
);
    import rti_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    t_phase     r_phase;
    t_phase     n_phase;
    logic       last;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_phase <= PH_U;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

    assign last   = (r_cnt == MAC_LAST);
    assign o_busy = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    if (i_opcode == OP_TEST) begin
                        o_cmd.ld_ray = 1'b1;
                        n_state      = S_DET;
                    end else if (i_vertex_select != VSEL_NONE) begin
                        o_cmd.ld_vertex = 1'b1;
                        n_state         = S_NORM;
                    end
                end
            end
            S_NORM: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = cross_step(AV_E1, BV_E2, DV_N, r_cnt);
                n_cnt        = last ? 3'd0 : r_cnt + 3'd1;
                if (last) n_state = S_IDLE;
            end
            S_DET: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = dot_step(AV_DIR, BV_N, 1'b1, r_cnt);
                n_cnt        = last ? 3'd0 : r_cnt + 3'd1;
                if (last) n_state = S_DCHK;
            end
            S_DCHK: begin
                if (i_stat.det_small) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.det_ld = 1'b1;
                    n_state      = S_PV;
                end
            end
            S_PV: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = cross_step(AV_DIR, BV_E2, DV_PV, r_cnt);
                n_cnt        = last ? 3'd0 : r_cnt + 3'd1;
                if (last) n_state = S_UNUM;
            end
            S_UNUM: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = dot_step(AV_TV, BV_PV, 1'b0, r_cnt);
                n_cnt        = last ? 3'd0 : r_cnt + 3'd1;
                if (last) begin
                    n_state = S_DSTART;
                    n_phase = PH_U;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    case (r_phase)
                        PH_U:    n_state = S_UCHK;
                        PH_V:    n_state = S_VCHK;
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_UCHK: begin
                if (i_stat.u_bad) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.u_ld = 1'b1;
                    n_state    = S_QV;
                end
            end
            S_QV: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = cross_step(AV_TV, BV_E1, DV_QV, r_cnt);
                n_cnt        = last ? 3'd0 : r_cnt + 3'd1;
                if (last) n_state = S_VNUM;
            end
            S_VNUM: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = dot_step(AV_DIR, BV_QV, 1'b0, r_cnt);
                n_cnt        = last ? 3'd0 : r_cnt + 3'd1;
                if (last) begin
                    n_state = S_DSTART;
                    n_phase = PH_V;
                end
            end
            S_VCHK: begin
                if (i_stat.v_bad) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_TNUM;
                end
            end
            S_TNUM: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = dot_step(AV_E2, BV_QV, 1'b0, r_cnt);
                n_cnt        = last ? 3'd0 : r_cnt + 3'd1;
                if (last) begin
                    n_state = S_DSTART;
                    n_phase = PH_T;
                end
            end
            S_EMIT: begin
                o_cmd.emit_hit = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/ray_triangle_intersect_unit.sv @@
// Top level of the fixed-point ray-triangle intersection unit.
//
//  Channel  | Ports                                            | Handshake
//  ---------+--------------------------------------------------+-------------------------
//  command  | i_opcode, i_vertex_select, i_pos_*, i_dir_*      | i_start high, o_busy low
//  result   | o_hit, o_distance, o_saturated                   | o_valid for one cycle
//  config   | i_cfg_wdata (epsilon)                            | i_cfg_we
//
// A vertex load is the write, then six multiply-accumulate steps for the normal.
// A test is made of six-step products on the one shared multiplier and three divider
// passes, each of the start, 42 one-bit steps and the done check; a test that misses
// early ends sooner.
// The result strobe is registered, in the cycle after the last cycle of a test; loads give no result.
// Reset is synchronous and active low; it clears the triangle, the normal and epsilon to 4.
// The receiver cannot stall: each result transaction is taken in its strobe cycle.
`default_nettype none

module ray_triangle_intersect_unit #(
    parameter int COORD_FRAC_BITS = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    output logic                                      o_busy,
    input  wire logic                                 i_opcode,
    input  wire logic [1:0]                           i_vertex_select,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_pos_x,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_pos_y,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_pos_z,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_dir_x,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_dir_y,
    input  wire logic signed [rti_pkg::COORD_W-1:0]   i_dir_z,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rti_pkg::EPS_W-1:0]            i_cfg_wdata,
    output logic                                      o_valid,
    output logic                                      o_hit,
    output logic signed [rti_pkg::COORD_W-1:0]        o_distance,
    output logic                                      o_saturated
);
    import rti_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    rti_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_opcode        (i_opcode),
        .i_vertex_select (i_vertex_select),
        .o_busy          (o_busy),
        .o_cmd           (cmd),
        .i_stat          (stat)
    );

    // Arithmetic and storage.
    rti_datapath #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_vertex_select (i_vertex_select),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_distance      (o_distance),
        .o_saturated     (o_saturated)
    );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the ray-triangle intersection unit.
`default_nettype none

module tb_top;
    import rti_pkg::*;

    localparam int  FRAC        = 12;
    localparam int  LIMIT       = 2000000;
    localparam int  RAND_ITEMS  = 850;
    localparam int  DRAIN_WAIT  = 220;
    localparam longint QCLAMP   = 64'sd1 << 40;

    typedef struct {
        logic                      hit;
        logic signed [COORD_W-1:0] distance;
        logic                      sat;
    } t_hit_rec;

    typedef struct {
        logic                      op;
        logic [1:0]                vsel;
        logic signed [COORD_W-1:0] p [3];
        logic signed [COORD_W-1:0] d [3];
        logic                      typed;
        t_hit_rec                  want;
    } t_cmd_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic op = OP_LOAD;
    logic [1:0] vsel = 2'd0;
    logic signed [COORD_W-1:0] px = '0, py = '0, pz = '0;
    logic signed [COORD_W-1:0] dx = '0, dy = '0, dz = '0;
    logic cfg_we = 1'b0;
    logic [EPS_W-1:0] cfg_wdata = '0;
    logic busy, valid, hit, sat;
    logic signed [COORD_W-1:0] distance;

    // Shadow copy of the triangle, its normal and the tolerance.
    logic signed [COORD_W-1:0] tri_vtx [9];
    logic signed [WIDE_W-1:0]  tri_nrm [3];
    logic [EPS_W-1:0]          tol;

    t_hit_rec hits_pending [$];
    t_cmd_row directed [$];
    int errors = 0;
    int cycles = 0;
    int item_no = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ray_triangle_intersect_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_opcode(op), .i_vertex_select(vsel),
        .i_pos_x(px), .i_pos_y(py), .i_pos_z(pz),
        .i_dir_x(dx), .i_dir_y(dy), .i_dir_z(dz),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_valid(valid), .o_hit(hit), .o_distance(distance), .o_saturated(sat)
    );

    // Truncating fixed-point quotient with the magnitude clamp.
    function automatic longint fx_div(logic signed [127:0] num, logic signed [127:0] den);
        logic [127:0] n;
        logic [127:0] dd;
        logic [127:0] q;
        logic         neg;
        neg = num[127] ^ den[127];
        n   = num[127] ? -num : num;
        dd  = den[127] ? -den : den;
        q   = (n << FRAC) / dd;
        if (q > 128'(QCLAMP)) q = 128'(QCLAMP);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic signed [127:0] dot3(longint a0, longint a1, longint a2,
                                                 longint b0, longint b1, longint b2);
        logic signed [127:0] s;
        s = 128'(a0) * 128'(b0) + 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2);
        return s;
    endfunction

    task automatic store_vertex(logic [1:0] sel, logic signed [COORD_W-1:0] p [3]);
        longint e1 [3];
        longint e2 [3];
        if (sel == VSEL_NONE) return;
        for (int i = 0; i < 3; i++) tri_vtx[3*sel+i] = p[i];
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(tri_vtx[3+i]) - longint'(tri_vtx[i]);
            e2[i] = longint'(tri_vtx[6+i]) - longint'(tri_vtx[i]);
        end
        tri_nrm[0] = WIDE_W'(e1[1]*e2[2] - e1[2]*e2[1]);
        tri_nrm[1] = WIDE_W'(e1[2]*e2[0] - e1[0]*e2[2]);
        tri_nrm[2] = WIDE_W'(e1[0]*e2[1] - e1[1]*e2[0]);
    endtask

    // Moller-Trumbore test against the shadow triangle.
    function automatic t_hit_rec trace_ray(logic signed [COORD_W-1:0] p [3],
                                           logic signed [COORD_W-1:0] r [3]);
        t_hit_rec res;
        longint e1 [3], e2 [3], tv [3], pv [3], qv [3], dv [3];
        logic signed [127:0] det, adet, epsd;
        longint u, v, t, one, eps;
        res = '{1'b0, '0, 1'b0};
        one = 64'sd1 << FRAC;
        eps = longint'(tol);
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(tri_vtx[3+i]) - longint'(tri_vtx[i]);
            e2[i] = longint'(tri_vtx[6+i]) - longint'(tri_vtx[i]);
            tv[i] = longint'(p[i]) - longint'(tri_vtx[i]);
            dv[i] = longint'(r[i]);
        end
        det  = -dot3(dv[0], dv[1], dv[2], longint'(tri_nrm[0]), longint'(tri_nrm[1]),
                     longint'(tri_nrm[2]));
        adet = det[127] ? -det : det;
        epsd = 128'(tol) << (2*FRAC);
        if (adet < epsd || adet == 0) return res;
        pv[0] = dv[1]*e2[2] - dv[2]*e2[1];
        pv[1] = dv[2]*e2[0] - dv[0]*e2[2];
        pv[2] = dv[0]*e2[1] - dv[1]*e2[0];
        u = fx_div(dot3(tv[0], tv[1], tv[2], pv[0], pv[1], pv[2]), det);
        if (u < -eps || u > one + eps) return res;
        qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
        qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
        qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
        v = fx_div(dot3(dv[0], dv[1], dv[2], qv[0], qv[1], qv[2]), det);
        if (v < -eps || u + v > one + eps) return res;
        t = fx_div(dot3(e2[0], e2[1], e2[2], qv[0], qv[1], qv[2]), det);
        res.hit = 1'b1;
        if (t > 64'sd8388607) begin
            t = 64'sd8388607;
            res.sat = 1'b1;
        end else if (t < -64'sd8388608) begin
            t = -64'sd8388608;
            res.sat = 1'b1;
        end
        res.distance = COORD_W'(t);
        return res;
    endfunction

    // Present one command and hold it until the unit takes the transaction.
    task automatic issue(t_cmd_row c);
        start <= 1'b1;
        op    <= c.op;
        vsel  <= c.vsel;
        px <= c.p[0]; py <= c.p[1]; pz <= c.p[2];
        dx <= c.d[0]; dy <= c.d[1]; dz <= c.d[2];
        @(posedge clk);
        while (busy) @(posedge clk);
        if (c.op == OP_LOAD) begin
            store_vertex(c.vsel, c.p);
        end else begin
            if (c.typed) hits_pending.push_back(c.want);
            else hits_pending.push_back(trace_ray(c.p, c.d));
        end
        item_no++;
    endtask

    // Random gaps between commands, none in the middle stretch.
    task automatic maybe_gap();
        if ((item_no < 300 || item_no > 450) && $urandom_range(99) < 22) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Tolerance writes happen only with the unit drained.
    task automatic set_tol(logic [EPS_W-1:0] val);
        start <= 1'b0;
        @(posedge clk);
        while (hits_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        tol = val;
    endtask

    function automatic logic signed [COORD_W-1:0] rnd_coord();
        case ($urandom_range(9))
            0: return COORD_W'($urandom);
            1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            2: return COORD_W'($signed($urandom_range(2097152)) - 1048576);
            default: return COORD_W'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic t_cmd_row mk_row(logic o, logic [1:0] s, int x, int y, int z,
                                        int a, int b, int c);
        t_cmd_row r;
        r.op = o; r.vsel = s;
        r.p[0] = COORD_W'(x); r.p[1] = COORD_W'(y); r.p[2] = COORD_W'(z);
        r.d[0] = COORD_W'(a); r.d[1] = COORD_W'(b); r.d[2] = COORD_W'(c);
        r.typed = 1'b0;
        r.want  = '{1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic t_cmd_row mk_miss(t_cmd_row r);
        r.typed = 1'b1;
        return r;
    endfunction

    // Build a random command: mostly rays aimed at the current triangle.
    function automatic t_cmd_row rnd_cmd(int slot);
        t_cmd_row c;
        longint tgt;
        int a, b;
        c.typed = 1'b0;
        c.want  = '{1'b0, '0, 1'b0};
        for (int i = 0; i < 3; i++) begin
            c.p[i] = rnd_coord();
            c.d[i] = rnd_coord();
        end
        if (slot < 3) begin
            c.op   = OP_LOAD;
            c.vsel = 2'(slot);
            if ($urandom_range(29) == 0) c.vsel = VSEL_NONE;
        end else if ($urandom_range(99) < 6) begin
            c.op   = OP_LOAD;
            c.vsel = 2'($urandom);
        end else begin
            c.op   = OP_TEST;
            c.vsel = 2'($urandom);
            if ($urandom_range(99) < 65) begin
                a = $urandom_range(4300);
                b = $urandom_range(4300 - ((a > 4300) ? 4300 : a));
                for (int i = 0; i < 3; i++) begin
                    tgt = longint'(tri_vtx[i])
                        + ((longint'(tri_vtx[3+i]) - longint'(tri_vtx[i])) * a >>> FRAC)
                        + ((longint'(tri_vtx[6+i]) - longint'(tri_vtx[i])) * b >>> FRAC)
                        - longint'(c.p[i]);
                    if (tgt <= 64'sd8388607 && tgt >= -64'sd8388608)
                        c.d[i] = COORD_W'(tgt);
                end
            end
        end
        return c;
    endfunction

    // Result checker: each strobe pops the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && valid) begin
            if (hits_pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: hit=%0b dist=%0d sat=%0b",
                                           hit, distance, sat);
            end else begin
                t_hit_rec w;
                w = hits_pending.pop_front();
                if (w.hit !== hit || w.distance !== distance || w.sat !== sat) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp hit=%0b dist=%0d sat=%0b",
                                  " got hit=%0b dist=%0d sat=%0b"},
                                 w.hit, w.distance, w.sat, hit, distance, sat);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        t_cmd_row c;
        logic [EPS_W-1:0] tol_set [5];
        for (int i = 0; i < 9; i++) tri_vtx[i] = '0;
        for (int i = 0; i < 3; i++) tri_nrm[i] = '0;
        tol = EPS_RESET;
        tol_set[0] = 16'd0; tol_set[1] = 16'hFFFF; tol_set[2] = 16'd1;
        tol_set[3] = EPS_RESET; tol_set[4] = 16'd0;

        // Directed table: flat triangle after reset, unit triangle, extremes.
        directed.push_back(mk_miss(mk_row(OP_TEST, 2'd0, 0, 0, 0, 4096, 4096, 4096)));
        directed.push_back(mk_row(OP_LOAD, 2'd1, 4096, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(OP_LOAD, 2'd2, 0, 4096, 0, 0, 0, 0));
        directed.push_back(mk_row(OP_TEST, 2'd0, 1024, 1024, 4096, 0, 0, -4096));
        directed.push_back(mk_row(OP_TEST, 2'd0, 1024, 1024, -4096, 0, 0, 4096));
        directed.push_back(mk_row(OP_TEST, 2'd0, 8192, 8192, 4096, 0, 0, -4096));
        directed.push_back(mk_row(OP_TEST, 2'd0, 0, 0, 4096, 0, 0, -4096));
        directed.push_back(mk_row(OP_TEST, 2'd0, 4096, 0, 4096, 0, 0, -4096));
        directed.push_back(mk_row(OP_TEST, 2'd0, 1000, 1000, 8388607, 0, 0, -4096));
        directed.push_back(mk_row(OP_TEST, 2'd0, 1000, 1000, 8388607, 0, 0, -2));
        directed.push_back(mk_row(OP_TEST, 2'd0, 1000, 1000, -8388608, 0, 0, -3));
        directed.push_back(mk_row(OP_LOAD, 2'd3, 8388607, -8388608, 77, 0, 0, 0));
        directed.push_back(mk_row(OP_TEST, 2'd1, 1024, 1024, 4096, 5, 7, -4096));
        directed.push_back(mk_row(OP_LOAD, 2'd0, -8388608, -8388608, -8388608, 0, 0, 0));
        directed.push_back(mk_row(OP_LOAD, 2'd1, 8388607, -8388608, 8388607, 0, 0, 0));
        directed.push_back(mk_row(OP_LOAD, 2'd2, -8388608, 8388607, 8388607, 0, 0, 0));
        directed.push_back(mk_row(OP_TEST, 2'd0, 8388607, 8388607, 8388607,
                                  -8388608, -8388608, -8388608));
        directed.push_back(mk_row(OP_TEST, 2'd0, -8388608, 0, 0, 8388607, 8388607, 8388607));
        directed.push_back(mk_row(OP_TEST, 2'd0, 0, 0, 0, 1, -1, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            issue(directed[i]);
            maybe_gap();
        end

        // Zero tolerance: a ray parallel to the plane has a zero determinant.
        set_tol(16'd0);
        issue(mk_row(OP_LOAD, 2'd0, 0, 0, 0, 0, 0, 0));
        issue(mk_row(OP_LOAD, 2'd1, 4096, 0, 0, 0, 0, 0));
        issue(mk_row(OP_LOAD, 2'd2, 0, 4096, 0, 0, 0, 0));
        issue(mk_miss(mk_row(OP_TEST, 2'd0, 100, 100, 4096, 4096, 0, 0)));
        issue(mk_row(OP_TEST, 2'd0, 1000, 1000, 8388607, 0, 0, -1));
        issue(mk_row(OP_TEST, 2'd0, 0, 0, 4096, 0, 0, -4096));

        // Random part in phases, each of which sets the tolerance first.
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 3) set_tol(16'($urandom));
            else set_tol(tol_set[ph]);
            for (int k = 0; k < RAND_ITEMS / 5; k++) begin
                c = rnd_cmd((k % 40) < 3 ? (k % 40) : 3);
                issue(c);
                maybe_gap();
            end
        end
        start <= 1'b0;

        while (hits_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
